// ===== hdl/pcpm_pkg.sv =====
// Shared types and constants of the phase current power meter.
package pcpm_pkg;

	localparam int ADC_BITS     = 12;
	localparam int SUM_W        = ADC_BITS + 1;
	localparam int GAIN_W       = 16;
	localparam int SUPPLY_W     = 16;
	localparam int CUR_W        = 16;
	localparam int PWR_W        = 23;
	localparam int CNT_W        = 16;
	localparam int CFG_W        = 23;
	localparam int CFG_IDX_W    = 3;
	localparam int GAIN_SHIFT   = 9;
	localparam int GPROD_W      = SUM_W + GAIN_W;
	localparam int FULL_W       = GPROD_W - GAIN_SHIFT;
	localparam int P_W          = FULL_W + SUPPLY_W;
	localparam int Y_W          = 30;
	localparam int RECIP_W      = 24;
	localparam int RECIP_SHIFT  = 30;
	localparam int T_W          = Y_W + RECIP_W;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam int S_DATA_W     = ((2 * ADC_BITS + 7) / 8) * 8;
	localparam int S_USER_W     = 2;
	localparam int M_DATA_W     = ((CUR_W + PWR_W + 7) / 8) * 8;
	localparam int M_USER_W     = 1;

	localparam logic [ADC_BITS-1:0] ADC_MID   = ADC_BITS'(1 << (ADC_BITS - 1));
	localparam logic [RECIP_W-1:0]  RECIP_125 = 24'd8589934;
	localparam logic [63:0]         PWR_OVF   = 64'd8388608000;
	localparam logic [Y_W-1:0]      DIV_125   = 30'd125;

	localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd256;
	localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 16'd24000;
	localparam logic [PWR_W-1:0]    FLOOR_RST  = 23'd0;
	localparam logic [PWR_W-1:0]    MAX_RST    = 23'd4294967;
	localparam logic [CNT_W-1:0]    NEEDED_RST = 16'd64;

	typedef enum logic [1:0] {
		CMD_IDLE    = 2'd0,
		CMD_MEASURE = 2'd1,
		CMD_RESET   = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN   = 3'd0,
		REG_SUPPLY = 3'd1,
		REG_FLOOR  = 3'd2,
		REG_MAX    = 3'd3,
		REG_NEEDED = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             measure;
		logic             ready;
		logic [SUM_W-1:0] sum;
	} job_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain;
		logic [SUPPLY_W-1:0] supply;
		logic [PWR_W-1:0]    floor_mw;
		logic [PWR_W-1:0]    max_mw;
	} calc_cfg_t;

endpackage

// ===== hdl/pcpm_front.sv =====
// Front end: accepts beats, tracks zero-offset calibration and builds back-end jobs.
module pcpm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pcpm_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [pcpm_pkg::S_USER_W-1:0]  s_tuser,
	input  logic [pcpm_pkg::CNT_W-1:0]     zero_needed,
	input  logic                           full,
	output logic                           push,
	output pcpm_pkg::job_t                 job
);
	import pcpm_pkg::*;

	function automatic logic [ADC_BITS-1:0] ema_step(input logic [ADC_BITS-1:0] z,
			input logic [ADC_BITS-1:0] s);
		logic [ADC_BITS+4:0] acc;
		acc = (ADC_BITS+5)'({z, 5'b0}) - (ADC_BITS+5)'(z) + (ADC_BITS+5)'(s);
		return acc[ADC_BITS+4:5];
	endfunction

	function automatic logic [ADC_BITS-1:0] abs_diff(input logic [ADC_BITS-1:0] x,
			input logic [ADC_BITS-1:0] z);
		return (x >= z) ? x - z : z - x;
	endfunction

	logic [ADC_BITS-1:0] za_q, zb_q, za_d, zb_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
	logic                cal_q, cal_d;
	logic [ADC_BITS-1:0] ia, ib;
	cmd_t                cmd;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;
	assign ia       = s_tdata[ADC_BITS-1:0];
	assign ib       = s_tdata[2*ADC_BITS-1:ADC_BITS];
	assign cmd      = cmd_t'(s_tuser[1:0]);
	assign cnt_inc  = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		za_d = za_q;
		zb_d = zb_q;
		cnt_d = cnt_q;
		cal_d = cal_q;
		job.measure = 1'b0;
		case (cmd)
			CMD_IDLE: begin
				za_d = ema_step(za_q, ia);
				zb_d = ema_step(zb_q, ib);
				cnt_d = cnt_inc;
				cal_d = cal_q || (cnt_inc >= zero_needed);
			end
			CMD_MEASURE: begin
				job.measure = cal_q;
			end
			CMD_RESET: begin
				za_d = ADC_MID;
				zb_d = ADC_MID;
				cnt_d = '0;
				cal_d = 1'b0;
			end
			default: begin
			end
		endcase
		job.ready = cal_d;
		job.sum = SUM_W'(abs_diff(ia, za_q)) + SUM_W'(abs_diff(ib, zb_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			za_q <= ADC_MID;
			zb_q <= ADC_MID;
			cnt_q <= '0;
			cal_q <= 1'b0;
		end else if (push) begin
			za_q <= za_d;
			zb_q <= zb_d;
			cnt_q <= cnt_d;
			cal_q <= cal_d;
		end
	end

endmodule

// ===== hdl/pcpm_queue.sv =====
// Short job queue between the front and back ends.
module pcpm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcpm_pkg::job_t job_in,
	output logic           full,
	input  logic           pop,
	output pcpm_pkg::job_t job_out,
	output logic           empty
);
	import pcpm_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full    = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign job_out = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/pcpm_back.sv =====
// Back end: current and power arithmetic sequencer with the output register.
module pcpm_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pcpm_pkg::calc_cfg_t            cfg,
	input  logic                           empty,
	input  pcpm_pkg::job_t                 job,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pcpm_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [pcpm_pkg::M_USER_W-1:0]  m_tuser
);
	import pcpm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL2,
		ST_MUL3,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [FULL_W-1:0]   full_q;
	logic [P_W-1:0]      p_q;
	logic [Y_W-1:0]      y_q;
	logic [T_W-1:0]      t_q;
	logic                ovf_q;
	logic                ready_q;
	logic                valid_q;
	logic [CUR_W-1:0]    cur_q;
	logic [PWR_W-1:0]    pwr_q;
	logic                zr_q;

	logic                out_free;
	logic                out_load;
	logic [GPROD_W-1:0]  gprod;
	logic [63:0]         p_ext;
	logic [PWR_W-1:0]    q0;
	logic [Y_W-1:0]      qm, rem;
	logic [PWR_W:0]      quo, floored;
	logic [PWR_W-1:0]    pwr_fin;
	logic [CUR_W-1:0]    cur_sat;

	assign out_free = !valid_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && !empty && (job.measure || out_free);
	assign out_load = ((state_q == ST_IDLE) && pop && !job.measure) ||
		((state_q == ST_FIN) && out_free);
	assign gprod    = GPROD_W'(job.sum) * GPROD_W'(cfg.gain);
	assign p_ext    = 64'(p_q);

	always_comb begin
		q0 = t_q[RECIP_SHIFT+PWR_W-1:RECIP_SHIFT];
		qm = Y_W'({q0, 7'b0}) - Y_W'({q0, 2'b0}) + Y_W'(q0);
		rem = y_q - qm;
		quo = (PWR_W+1)'(q0) + (PWR_W+1)'(rem >= DIV_125);
		floored = (quo < (PWR_W+1)'(cfg.floor_mw)) ? '0 : quo;
		if (ovf_q || (floored > (PWR_W+1)'(cfg.max_mw))) begin
			pwr_fin = cfg.max_mw;
		end else begin
			pwr_fin = floored[PWR_W-1:0];
		end
		cur_sat = (full_q > FULL_W'({CUR_W{1'b1}})) ? {CUR_W{1'b1}} : CUR_W'(full_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (job.measure) begin
							full_q <= gprod[GPROD_W-1:GAIN_SHIFT];
							ready_q <= job.ready;
							state_q <= ST_MUL2;
						end else begin
							cur_q <= '0;
							pwr_q <= '0;
							zr_q <= job.ready;
						end
					end
				end
				ST_MUL2: begin
					p_q <= P_W'(full_q) * P_W'(cfg.supply);
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					ovf_q <= (p_ext >= PWR_OVF);
					y_q <= p_ext[32:3];
					t_q <= T_W'(p_ext[32:3]) * T_W'(RECIP_125);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						cur_q <= cur_sat;
						pwr_q <= pwr_fin;
						zr_q <= ready_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = M_DATA_W'({pwr_q, cur_q});
	assign m_tuser  = zr_q;

endmodule

// ===== hdl/phase_current_power_meter_core.sv =====
// Phase current power meter: configuration registers and front/queue/back assembly.
//
// Input stream: one beat per ADC sample pair, command in s_tuser. Idle beats
// update the per-channel zero offsets and the idle-sample count, measure beats
// produce current and power, reset beats clear calibration.
// Output stream: exactly one beat per input beat, in order.
// The front end takes a beat in the cycle it is offered, unless the two-entry
// job queue is full. The back end pops one job at a time: a non-measure job
// (or a measure before ready) goes from the queue straight to the output
// register; a measure job runs the gain multiply, supply multiply, reciprocal
// multiply for the divide by 1000, then correction, floor and clamp, in order.
// Other beats sustain one beat per cycle while m_tready is high; the back end
// takes no new job until the multiply sequence of a measure beat is done.
// When m_tready is low the result holds in the output register; the back end
// stalls, the queue fills and then s_tready drops.
// Reset (arst_n low) clears calibration, the queue and the output valid, and
// loads register defaults. Configuration writes apply the next cycle.
module phase_current_power_meter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pcpm_pkg::S_DATA_W-1:0]   s_tdata,  // phase A counts, phase B counts
	input  logic [pcpm_pkg::S_USER_W-1:0]   s_tuser,  // command
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pcpm_pkg::M_DATA_W-1:0]   m_tdata,  // current_ma, power_mw, zero pad
	output logic [pcpm_pkg::M_USER_W-1:0]   m_tuser,  // zero_ready
	input  logic                            cfg_we,
	input  logic [pcpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcpm_pkg::CFG_W-1:0]      cfg_wdata
);
	import pcpm_pkg::*;

	calc_cfg_t        calc_cfg_q;
	logic [CNT_W-1:0] needed_q;
	logic             q_full, q_empty, q_push, q_pop;
	job_t             job_in, job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_cfg_q.gain <= GAIN_RST;
			calc_cfg_q.supply <= SUPPLY_RST;
			calc_cfg_q.floor_mw <= FLOOR_RST;
			calc_cfg_q.max_mw <= MAX_RST;
			needed_q <= NEEDED_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GAIN:   calc_cfg_q.gain <= cfg_wdata[GAIN_W-1:0];
				REG_SUPPLY: calc_cfg_q.supply <= cfg_wdata[SUPPLY_W-1:0];
				REG_FLOOR:  calc_cfg_q.floor_mw <= cfg_wdata[PWR_W-1:0];
				REG_MAX:    calc_cfg_q.max_mw <= cfg_wdata[PWR_W-1:0];
				REG_NEEDED: needed_q <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pcpm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.zero_needed (needed_q),
		.full        (q_full),
		.push        (q_push),
		.job         (job_in)
	);

	pcpm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.job_in  (job_in),
		.full    (q_full),
		.pop     (q_pop),
		.job_out (job_out),
		.empty   (q_empty)
	);

	pcpm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (calc_cfg_q),
		.empty    (q_empty),
		.job      (job_out),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== test/pcpm_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the phase current power meter: predicts every output beat and compares it.
module pcpm_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [pcpm_pkg::S_DATA_W-1:0]  s_tdata,  // phase A counts, phase B counts
	input  logic [pcpm_pkg::S_USER_W-1:0]  s_tuser,  // command
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [pcpm_pkg::M_DATA_W-1:0]  m_tdata,  // current_ma, power_mw, zero pad
	input  logic [pcpm_pkg::M_USER_W-1:0]  m_tuser,  // zero_ready
	input  logic                           cfg_we,
	input  logic [pcpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcpm_pkg::CFG_W-1:0]     cfg_wdata,
	output int                             fail_count,
	output int                             readings_pending
);
	import pcpm_pkg::*;

	localparam int REPORT_LIMIT = 40;

	typedef struct packed {
		logic [CUR_W-1:0] current_ma;
		logic [PWR_W-1:0] power_mw;
		logic             zero_ready;
	} reading_t;

	logic [GAIN_W-1:0]   gain;
	logic [SUPPLY_W-1:0] supply;
	logic [PWR_W-1:0]    floor_lim;
	logic [PWR_W-1:0]    ceil_lim;
	logic [CNT_W-1:0]    needed;
	logic [ADC_BITS-1:0] offset_a;
	logic [ADC_BITS-1:0] offset_b;
	logic [CNT_W-1:0]    idle_count;
	logic                calibrated;
	reading_t            readings_due[$];
	reading_t            want;
	int                  beat_no;

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		if (fail_count < REPORT_LIMIT)
			$display("[%0t] output beat %0d %s: got %0d, expected %0d",
				$time, beat_no, what, got, exp_val);
		fail_count++;
	endtask

	function automatic reading_t next_reading(input logic [S_USER_W-1:0] cmd,
		input logic [ADC_BITS-1:0] ia, input logic [ADC_BITS-1:0] ib);
		reading_t            r;
		logic [ADC_BITS-1:0] da;
		logic [ADC_BITS-1:0] db;
		logic [63:0]         full;
		logic [63:0]         mw;
		r = '0;
		if (cmd == CMD_IDLE) begin
			offset_a = ADC_BITS'((32'(offset_a) * 32'd31 + 32'(ia)) >> 5);
			offset_b = ADC_BITS'((32'(offset_b) * 32'd31 + 32'(ib)) >> 5);
			if (idle_count != '1)
				idle_count = idle_count + 1'b1;
			if (idle_count >= needed)
				calibrated = 1'b1;
		end else if (cmd == CMD_MEASURE && calibrated) begin
			da = (ia >= offset_a) ? ia - offset_a : offset_a - ia;
			db = (ib >= offset_b) ? ib - offset_b : offset_b - ib;
			full = ((64'(da) + 64'(db)) * 64'(gain)) >> GAIN_SHIFT;
			mw = full * 64'(supply) / 64'd1000;
			if (mw < 64'(floor_lim))
				mw = '0;
			if (mw > 64'(ceil_lim))
				mw = 64'(ceil_lim);
			r.current_ma = (full > 64'hFFFF) ? '1 : full[CUR_W-1:0];
			r.power_mw = mw[PWR_W-1:0];
		end else if (cmd == CMD_RESET) begin
			offset_a = ADC_MID;
			offset_b = ADC_MID;
			idle_count = '0;
			calibrated = 1'b0;
		end
		r.zero_ready = calibrated;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain = GAIN_RST;
			supply = SUPPLY_RST;
			floor_lim = FLOOR_RST;
			ceil_lim = MAX_RST;
			needed = NEEDED_RST;
			offset_a = ADC_MID;
			offset_b = ADC_MID;
			idle_count = '0;
			calibrated = 1'b0;
			readings_due.delete();
			readings_pending = 0;
			fail_count = 0;
			beat_no = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
				REG_GAIN:   gain = cfg_wdata[GAIN_W-1:0];
				REG_SUPPLY: supply = cfg_wdata[SUPPLY_W-1:0];
				REG_FLOOR:  floor_lim = cfg_wdata[PWR_W-1:0];
				REG_MAX:    ceil_lim = cfg_wdata[PWR_W-1:0];
				REG_NEEDED: needed = cfg_wdata[CNT_W-1:0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				readings_due.push_back(next_reading(s_tuser, s_tdata[ADC_BITS-1:0],
					s_tdata[ADC_BITS +: ADC_BITS]));
			if (m_tvalid && m_tready) begin
				beat_no++;
				if (readings_due.size() == 0) begin
					report_mismatch("beat with no reading due, tdata", m_tdata, 0);
				end else begin
					want = readings_due.pop_front();
					if (m_tdata[CUR_W-1:0] !== want.current_ma)
						report_mismatch("current_ma", m_tdata[CUR_W-1:0], want.current_ma);
					if (m_tdata[CUR_W +: PWR_W] !== want.power_mw)
						report_mismatch("power_mw", m_tdata[CUR_W +: PWR_W], want.power_mw);
					if (m_tuser[0] !== want.zero_ready)
						report_mismatch("zero_ready", m_tuser[0], want.zero_ready);
				end
			end
			readings_pending = readings_due.size();
		end
	end

endmodule

// ===== test/tb_phase_current_power_meter_core.sv =====
`timescale 1ns / 100ps
// Testbench top for the phase current power meter: stimulus, back-pressure and verdict.
module tb_phase_current_power_meter_core;
	import pcpm_pkg::*;

	localparam logic [S_USER_W-1:0] CMD_UNUSED = 2'd3;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 150;
	localparam int HOLD_PHASE   = 2;
	localparam int HOLD_CYCLES  = 200;
	localparam int SOAK_ITEMS   = 40;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 500000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;  // phase A counts, phase B counts
	logic [S_USER_W-1:0]  s_tuser;  // command
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;  // current_ma, power_mw, zero pad
	logic [M_USER_W-1:0]  m_tuser;  // zero_ready
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	int                   fail_count;
	int                   readings_pending;
	bit                   hold_req;
	bit                   quiet_run;

	phase_current_power_meter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pcpm_scoreboard scoreboard (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.fail_count       (fail_count),
		.readings_pending (readings_pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic send_beat(input logic [S_USER_W-1:0] cmd,
		input logic [ADC_BITS-1:0] ia, input logic [ADC_BITS-1:0] ib);
		@(negedge clk);
		if (!quiet_run && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= S_DATA_W'({ib, ia});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (readings_pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
	endtask

	task automatic configure(input logic [GAIN_W-1:0] g, input logic [SUPPLY_W-1:0] v,
		input logic [PWR_W-1:0] lo, input logic [PWR_W-1:0] hi, input logic [CNT_W-1:0] need);
		write_reg(REG_GAIN, CFG_W'({$urandom, g}));
		write_reg(REG_SUPPLY, CFG_W'({$urandom, v}));
		write_reg(REG_FLOOR, CFG_W'(lo));
		write_reg(REG_MAX, CFG_W'(hi));
		write_reg(REG_NEEDED, CFG_W'({$urandom, need}));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic phase_settings(input int p);
		logic [GAIN_W-1:0] g;
		logic [PWR_W-1:0]  lo;
		logic [PWR_W-1:0]  hi;
		g = $urandom_range(0, 1) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(64, 2048));
		lo = $urandom_range(0, 1) ? '0 : PWR_W'($urandom_range(0, 50000));
		hi = $urandom_range(0, 1) ? MAX_RST : PWR_W'($urandom_range(0, 4294967));
		case (p)
		0: configure(GAIN_RST, SUPPLY_RST, FLOOR_RST, MAX_RST, NEEDED_RST);
		1: configure('1, '1, '0, MAX_RST, '0);
		2: configure(GAIN_W'($urandom_range(128, 1024)), SUPPLY_RST, '0, MAX_RST,
			CNT_W'($urandom_range(0, 8)));
		3: configure(g, '0, '0, '0, 16'd4);
		default: configure(g, SUPPLY_W'($urandom), lo, hi, CNT_W'($urandom_range(0, 12)));
		endcase
	endtask

	function automatic logic [ADC_BITS-1:0] pick_counts();
		if ($urandom_range(0, 2) == 0)
			return ADC_BITS'($urandom);
		return ADC_BITS'(int'(ADC_MID) + $urandom_range(0, 200) - 100);
	endfunction

	function automatic logic [S_USER_W-1:0] pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return CMD_IDLE;
		if (r < 93)
			return CMD_MEASURE;
		if (r < 97)
			return CMD_RESET;
		return CMD_UNUSED;
	endfunction

	initial begin : result_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("phase_current_power_meter_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_IDLE;
		cfg_we = 1'b0;
		cfg_index = REG_GAIN;
		cfg_wdata = '0;
		hold_req = 1'b0;
		quiet_run = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register defaults, not yet calibrated
		send_beat(CMD_MEASURE, 12'd0, 12'd4095);
		send_beat(CMD_UNUSED, 12'd4095, 12'd0);
		send_beat(CMD_IDLE, 12'd0, 12'd4095);
		send_beat(CMD_IDLE, 12'd4095, 12'd0);
		send_beat(CMD_RESET, 12'd4095, 12'd4095);

		// threshold zero, full-scale gain and supply
		drain();
		configure('1, '1, '0, MAX_RST, '0);
		send_beat(CMD_MEASURE, ADC_MID, ADC_MID);
		send_beat(CMD_IDLE, ADC_MID, ADC_MID);
		send_beat(CMD_MEASURE, 12'd0, 12'd4095);
		send_beat(CMD_MEASURE, 12'd4095, 12'd4095);
		send_beat(CMD_MEASURE, ADC_MID, ADC_MID);
		send_beat(CMD_MEASURE, ADC_MID + 12'd1, ADC_MID - 12'd1);
		send_beat(CMD_UNUSED, 12'd0, 12'd0);
		send_beat(CMD_RESET, 12'd0, 12'd0);
		send_beat(CMD_MEASURE, 12'd0, 12'd0);

		// floor above ceiling
		drain();
		configure(GAIN_RST, SUPPLY_RST, 23'd60000, 23'd30000, 16'd2);
		send_beat(CMD_IDLE, ADC_MID, ADC_MID);
		send_beat(CMD_IDLE, ADC_MID, ADC_MID);
		send_beat(CMD_MEASURE, 12'd0, 12'd4095);
		send_beat(CMD_MEASURE, ADC_MID + 12'd1000, ADC_MID);
		send_beat(CMD_MEASURE, 12'd4095, 12'd0);

		// zero gain and supply, largest threshold: calibration stays pending
		drain();
		configure('0, '0, '0, '0, '1);
		quiet_run = 1'b1;
		send_beat(CMD_RESET, pick_counts(), pick_counts());
		send_beat(CMD_MEASURE, pick_counts(), pick_counts());
		for (int n = 0; n < SOAK_ITEMS; n++)
			send_beat(CMD_IDLE, pick_counts(), pick_counts());
		send_beat(CMD_MEASURE, pick_counts(), pick_counts());
		send_beat(CMD_UNUSED, pick_counts(), pick_counts());
		quiet_run = 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			drain();
			phase_settings(p);
			quiet_run = (p == PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == HOLD_PHASE && n == 40)
					hold_req = 1'b1;
				send_beat(pick_command(), pick_counts(), pick_counts());
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && readings_pending == 0)
			$display("phase_current_power_meter_core regression: pass");
		else
			$display("phase_current_power_meter_core regression: fail");
		$finish;
	end

endmodule
